FILE: hw/rtl/positional_pid_with_integral_window_assert.svh
// Assertion macros used by the ppid_integ module.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef POSITIONAL_PID_WITH_INTEGRAL_WINDOW_ASSERT_SVH
`define POSITIONAL_PID_WITH_INTEGRAL_WINDOW_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPID_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ppid_pkg.sv
package ppid_pkg;

	localparam int POS_WIDTH      = 16;
	localparam int GAIN_FRAC_BITS = 8;

	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 31;
	localparam int WIN_W      = 16;
	localparam int OUT_W      = 32;
	localparam int SUM_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Error and its difference from the previous tick.
	localparam int E_W   = POS_WIDTH + 1;
	localparam int DE_W  = POS_WIDTH + 2;
	localparam int ACC_W = ((E_W > SUM_W) ? E_W : SUM_W) + 1;
	localparam int MAG_W = E_W;
	localparam int CMP_W = (MAG_W > WIN_W) ? MAG_W : WIN_W;

	// Scaled terms; gains are widened by a zero sign bit before multiplying.
	localparam int P_W   = GAIN_W + 1 + E_W;
	localparam int I_W   = GAIN_W + 1 + SUM_W;
	localparam int D_W   = GAIN_W + 1 + DE_W;
	localparam int LIM_W = LIMIT_W + GAIN_FRAC_BITS + 1;
	localparam int CL_W  = ((I_W > LIM_W) ? I_W : LIM_W) + 1;
	localparam int PD_W  = ((P_W > D_W) ? P_W : D_W) + 1;
	localparam int TOT_W = ((PD_W > I_W) ? PD_W : I_W) + 1;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_ERR_WINDOW  = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX     = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN     = CFG_IDX_W'(6);

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [LIMIT_W-1:0] integ_term_limit;
		logic [WIN_W-1:0]   error_window;
		logic [OUT_W-1:0]   out_max;
		logic [OUT_W-1:0]   out_min;
	} cfg_t;

	typedef struct packed {
		logic [E_W-1:0]   e;
		logic [DE_W-1:0]  de;
		logic [SUM_W-1:0] sum;
	} err_t;

	typedef struct packed {
		logic [P_W-1:0] p;
		logic [I_W-1:0] i;
		logic [D_W-1:0] d;
	} prod_t;

endpackage

FILE: hw/rtl/ppid_integ.sv
`include "positional_pid_with_integral_window_assert.svh"

module ppid_integ import ppid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [POS_WIDTH-1:0] measured_pos,
	input  logic [POS_WIDTH-1:0] target_pos,
	input  logic                 restart,
	input  logic [WIN_W-1:0]     error_window,
	output logic                 err_valid,
	output err_t                 err,
	input  logic                 err_ready
);

	logic                 valid_s1;
	logic [POS_WIDTH-1:0] meas_s1;
	logic [POS_WIDTH-1:0] targ_s1;
	logic                 restart_s1;
	logic                 valid_s2;
	err_t                 err_s2;
	logic [E_W-1:0]       prev_error_q;
	logic [SUM_W-1:0]     error_sum_q;

	logic                    en2;
	logic                    adv;
	logic signed [E_W-1:0]   e_c;
	logic [MAG_W-1:0]        mag_c;
	logic                    too_far;
	logic signed [E_W-1:0]   prev_c;
	logic signed [DE_W-1:0]  de_c;
	logic signed [SUM_W-1:0] base_c;
	logic signed [ACC_W-1:0] acc_c;
	logic                    fits;
	logic [SUM_W-1:0]        sat_c;
	logic [SUM_W-1:0]        sum_next;

	assign en2      = !valid_s2 || err_ready;
	assign adv      = valid_s1 && en2;
	assign in_ready = !valid_s1 || adv;

	assign e_c     = E_W'($signed(targ_s1)) - E_W'($signed(meas_s1));
	assign mag_c   = e_c[E_W-1] ? MAG_W'(-e_c) : MAG_W'(e_c);
	assign too_far = CMP_W'(mag_c) > CMP_W'(error_window);

	// A restart makes the previous error equal to the present one, so D is zero.
	assign prev_c = restart_s1 ? e_c : $signed(prev_error_q);
	assign de_c   = DE_W'(e_c) - DE_W'(prev_c);
	assign base_c = restart_s1 ? '0 : $signed(error_sum_q);
	assign acc_c  = ACC_W'(base_c) + ACC_W'(e_c);

	// The sum fits when all bits above the signed 32-bit range copy the sign.
	assign fits  = (&acc_c[ACC_W-1:SUM_W-1]) || !(|acc_c[ACC_W-1:SUM_W-1]);
	assign sat_c = fits ? acc_c[SUM_W-1:0] :
		(acc_c[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}});
	assign sum_next = too_far ? '0 : sat_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			prev_error_q <= '0;
			error_sum_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (adv) begin
				prev_error_q <= e_c;
				error_sum_q  <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meas_s1    <= measured_pos;
			targ_s1    <= target_pos;
			restart_s1 <= restart;
		end
		if (adv) begin
			err_s2.e   <= e_c;
			err_s2.de  <= de_c;
			err_s2.sum <= sum_next;
		end
	end

	assign err_valid = valid_s2;
	assign err       = err_s2;

	`PPID_ASSERT_NEXT(a_window_clears_sum, adv && too_far, error_sum_q == '0,
		"integral not cleared for an error outside the window")
	`PPID_ASSERT_NEXT(a_restart_no_deriv, adv && restart_s1, err_s2.de == '0,
		"derivative difference not zero on a restart item")
	`PPID_ASSERT_NOW(a_stall_full, !in_ready, valid_s1 && valid_s2 && !err_ready,
		"input held off while the front stages have room")

endmodule

FILE: hw/rtl/ppid_mult.sv
module ppid_mult import ppid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              err_valid,
	input  err_t              err,
	output logic              err_ready,
	input  logic [GAIN_W-1:0] prop_gain,
	input  logic [GAIN_W-1:0] integ_gain,
	input  logic [GAIN_W-1:0] deriv_gain,
	output logic              prod_valid,
	output prod_t             prod,
	input  logic              prod_ready
);

	logic  valid_s3;
	prod_t prod_s3;

	logic                  en3;
	logic signed [P_W-1:0] p_c;
	logic signed [I_W-1:0] i_c;
	logic signed [D_W-1:0] d_c;

	assign en3       = !valid_s3 || prod_ready;
	assign err_ready = en3;

	// Gains are unsigned, so each gets a zero sign bit before the signed multiply.
	assign p_c = $signed({1'b0, prop_gain}) * $signed(err.e);
	assign i_c = $signed({1'b0, integ_gain}) * $signed(err.sum);
	assign d_c = $signed({1'b0, deriv_gain}) * $signed(err.de);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= err_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && err_valid) begin
			prod_s3.p <= p_c;
			prod_s3.i <= i_c;
			prod_s3.d <= d_c;
		end
	end

	assign prod_valid = valid_s3;
	assign prod       = prod_s3;

endmodule

FILE: hw/rtl/ppid_sum.sv
module ppid_sum import ppid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               prod_valid,
	input  prod_t              prod,
	output logic               prod_ready,
	input  logic [LIMIT_W-1:0] integ_term_limit,
	output logic               tot_valid,
	output logic [TOT_W-1:0]   total,
	input  logic               tot_ready
);

	logic            valid_s4;
	logic [PD_W-1:0] pd_s4;
	logic [I_W-1:0]  ic_s4;
	logic             valid_s5;
	logic [TOT_W-1:0] total_s5;

	logic                   en4;
	logic                   en5;
	logic signed [CL_W-1:0] lim_c;
	logic signed [CL_W-1:0] iw_c;
	logic signed [CL_W-1:0] ic_c;
	logic signed [PD_W-1:0] pd_c;

	assign en5        = !valid_s5 || tot_ready;
	assign en4        = !valid_s4 || en5;
	assign prod_ready = en4;

	// The limit is in output units and is scaled up to the gain fraction.
	assign lim_c = CL_W'(integ_term_limit) << GAIN_FRAC_BITS;
	assign iw_c  = CL_W'($signed(prod.i));

	always_comb begin
		ic_c = iw_c;
		if (ic_c > lim_c) begin
			ic_c = lim_c;
		end
		if (ic_c < -lim_c) begin
			ic_c = -lim_c;
		end
	end

	assign pd_c = PD_W'($signed(prod.p)) + PD_W'($signed(prod.d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en4) begin
				valid_s4 <= prod_valid;
			end
			if (en5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && prod_valid) begin
			pd_s4 <= pd_c;
			ic_s4 <= ic_c[I_W-1:0];
		end
		if (en5 && valid_s4) begin
			total_s5 <= TOT_W'($signed(pd_s4)) + TOT_W'($signed(ic_s4));
		end
	end

	assign tot_valid = valid_s5;
	assign total     = total_s5;

endmodule

FILE: hw/rtl/ppid_out.sv
module ppid_out import ppid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tot_valid,
	input  logic [TOT_W-1:0] total,
	output logic             tot_ready,
	input  logic [OUT_W-1:0] out_max,
	input  logic [OUT_W-1:0] out_min,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] drive_delta
);

	localparam logic [TOT_W-1:0] RND_BIAS = TOT_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

	logic             out_valid_q;
	logic [OUT_W-1:0] drive_delta_q;

	logic                    en;
	logic signed [TOT_W-1:0] biased_c;
	logic signed [TOT_W-1:0] q_c;
	logic signed [TOT_W-1:0] max_c;
	logic signed [TOT_W-1:0] min_c;
	logic signed [TOT_W-1:0] clamp_c;

	assign en        = !out_valid_q || out_ready;
	assign tot_ready = en;

	// Adding the bias to negative totals makes the shift truncate toward zero.
	assign biased_c = $signed(total) + $signed(total[TOT_W-1] ? RND_BIAS : '0);
	assign q_c      = biased_c >>> GAIN_FRAC_BITS;
	assign max_c    = TOT_W'($signed(out_max));
	assign min_c    = TOT_W'($signed(out_min));

	// Upper bound first, then lower, so inverted bounds give the lower bound.
	always_comb begin
		clamp_c = q_c;
		if (clamp_c > max_c) begin
			clamp_c = max_c;
		end
		if (clamp_c < min_c) begin
			clamp_c = min_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tot_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && tot_valid) begin
			drive_delta_q <= clamp_c[OUT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_delta = drive_delta_q;

endmodule

FILE: hw/rtl/positional_pid_with_integral_window.sv
// Channel   Handshake              Payload
// cfg       cfg_we                 cfg_index, cfg_data
// in        in_valid / in_ready    measured_pos, target_pos, restart
// out       out_valid / out_ready  drive_delta
//
// One item is accepted per cycle unless the output stalls; results pass stages s1 to s5.
// The error and the integral are both updated as an item leaves the input register.
// Every stage has its own valid bit, so bubbles close up while the output stalls.
// The input is held off only when the stage after the input register is full and blocked.
// Reset clears the configuration registers, the integral, the previous error and all valid bits.
module positional_pid_with_integral_window import ppid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [POS_WIDTH-1:0]  measured_pos,
	input  logic [POS_WIDTH-1:0]  target_pos,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_W-1:0]      drive_delta
);

	cfg_t cfg_q;

	logic             err_valid;
	err_t             err;
	logic             err_ready;
	logic             prod_valid;
	prod_t            prod;
	logic             prod_ready;
	logic             tot_valid;
	logic [TOT_W-1:0] total;
	logic             tot_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN:   cfg_q.prop_gain        <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain       <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain       <= cfg_data[GAIN_W-1:0];
				REG_INTEG_LIMIT: cfg_q.integ_term_limit <= cfg_data[LIMIT_W-1:0];
				REG_ERR_WINDOW:  cfg_q.error_window     <= cfg_data[WIN_W-1:0];
				REG_OUT_MAX:     cfg_q.out_max          <= cfg_data[OUT_W-1:0];
				REG_OUT_MIN:     cfg_q.out_min          <= cfg_data[OUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ppid_integ u_integ (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.measured_pos (measured_pos),
		.target_pos   (target_pos),
		.restart      (restart),
		.error_window (cfg_q.error_window),
		.err_valid    (err_valid),
		.err          (err),
		.err_ready    (err_ready)
	);

	ppid_mult u_mult (
		.clk        (clk),
		.arst_n     (arst_n),
		.err_valid  (err_valid),
		.err        (err),
		.err_ready  (err_ready),
		.prop_gain  (cfg_q.prop_gain),
		.integ_gain (cfg_q.integ_gain),
		.deriv_gain (cfg_q.deriv_gain),
		.prod_valid (prod_valid),
		.prod       (prod),
		.prod_ready (prod_ready)
	);

	ppid_sum u_sum (
		.clk              (clk),
		.arst_n           (arst_n),
		.prod_valid       (prod_valid),
		.prod             (prod),
		.prod_ready       (prod_ready),
		.integ_term_limit (cfg_q.integ_term_limit),
		.tot_valid        (tot_valid),
		.total            (total),
		.tot_ready        (tot_ready)
	);

	ppid_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.tot_valid   (tot_valid),
		.total       (total),
		.tot_ready   (tot_ready),
		.out_max     (cfg_q.out_max),
		.out_min     (cfg_q.out_min),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive_delta (drive_delta)
	);

endmodule
